@@ hw/rtl/can_command_frame_validator_core_defines.svh @@
// assertion macros used by the frame validator core
`ifndef CAN_COMMAND_FRAME_VALIDATOR_CORE_DEFINES_SVH
`define CAN_COMMAND_FRAME_VALIDATOR_CORE_DEFINES_SVH

// property that must hold at every edge outside reset
`define CFV_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequence that must hold at the edge after the antecedent
`define CFV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/cfv_pkg.sv @@
// types and constants of the can command frame validator
package cfv_pkg;

  // event kinds carried in the input tuser
  typedef enum logic [1:0] {
    CMD_FRAME   = 2'd0,
    CMD_TAKE    = 2'd1,
    CMD_SLOT    = 2'd2,
    CMD_RESPOND = 2'd3
  } cmd_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_TARGET_LIMIT = 2'd0,
    REG_CONTROL_ID   = 2'd1,
    REG_TEST_ID      = 2'd2
  } reg_idx_e;

  // link state codes
  localparam logic [1:0] LINK_READY  = 2'd0;
  localparam logic [1:0] LINK_PASSED = 2'd1;
  localparam logic [1:0] LINK_FAILED = 2'd2;

  // frame constants
  localparam logic [3:0]  FRAME_DLC    = 4'd8;
  localparam logic [31:0] PING_WORD    = 32'h474E_4950;
  localparam logic [31:0] PASS_WORD    = 32'h5353_4150;
  localparam logic [31:0] TEST_HIGH    = 32'h0000_0001;
  localparam logic [7:0]  CTRL_VERSION = 8'd1;
  localparam logic [7:0]  ENABLE_MASK  = 8'hFE;

  // register reset values
  localparam logic [14:0] TARGET_LIMIT_RST = 15'd1000;
  localparam logic [10:0] CONTROL_ID_RST   = 11'h100;
  localparam logic [10:0] TEST_ID_RST      = 11'h720;

  typedef struct packed {
    logic [14:0] target_limit;
    logic [10:0] control_frame_id;
    logic [10:0] test_request_id;
  } cfg_t;

  typedef struct packed {
    cmd_e        cmd;
    logic [10:0] frame_id;
    logic [3:0]  length_code;
    logic        fd_format;
    logic        rate_switch;
    logic [31:0] payload_low;
    logic [31:0] payload_high;
    logic        tx_accepted;
  } item_t;

  typedef struct packed {
    logic [1:0]         link_state;
    logic               reply_waiting;
    logic               send_reply;
    logic               command_waiting;
    logic               command_given;
    logic               cmd_enabled;
    logic [7:0]         cmd_sequence;
    logic signed [15:0] left_goal;
    logic signed [15:0] right_goal;
  } result_t;

endpackage

@@ hw/rtl/can_command_frame_validator_core.sv @@
// can command frame validator: stream usage
// one event beat in on s_axis (tuser selects the event), one result beat out
// on m_axis for every event beat. events: received frame, take command,
// transmit slot, request response. registers are set over the apb port
// (target limit at 0x0, control frame id at 0x4, test request id at 0x8)
// and should only change while no event is in flight.
// an accepted beat is held in an input register, evaluated against the link
// state and written to the result register once that register is free.
// throughput is one beat per cycle while m_axis_tready stays high, as the
// state update between the input and result registers is combinational.
// when m_axis_tready is low the result register holds its beat; one more
// input beat is still taken into the input register, after which
// s_axis_tready drops until the result is taken.
// reset clears the link to ready, drops any pending reply or command and
// restores the register defaults.
`include "can_command_frame_validator_core_defines.svh"

module can_command_frame_validator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // event channel
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // frame_id, length_code, fd_format, rate_switch, payload_low, payload_high,
  // tx_accepted, zero pad
  input  logic [87:0] s_axis_tdata,
  // cmd
  input  logic [1:0]  s_axis_tuser,
  // result channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // link_state, reply_waiting, send_reply, command_waiting, command_given,
  // cmd_enabled, cmd_sequence, left_goal, right_goal, zero pad
  output logic [47:0] m_axis_tdata,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfv_pkg::cfg_t    cfg;
  cfv_pkg::item_t   in_beat, in_q;
  cfv_pkg::result_t result, out_q;
  logic             in_vld_q, out_vld_q;
  logic             advance, fire;

  // input beat unpack
  assign in_beat.cmd          = cfv_pkg::cmd_e'(s_axis_tuser);
  assign in_beat.frame_id     = s_axis_tdata[10:0];
  assign in_beat.length_code  = s_axis_tdata[14:11];
  assign in_beat.fd_format    = s_axis_tdata[15];
  assign in_beat.rate_switch  = s_axis_tdata[16];
  assign in_beat.payload_low  = s_axis_tdata[48:17];
  assign in_beat.payload_high = s_axis_tdata[80:49];
  assign in_beat.tx_accepted  = s_axis_tdata[81];

  // flow control
  assign advance       = !out_vld_q || m_axis_tready;
  assign fire          = in_vld_q && advance;
  assign s_axis_tready = !in_vld_q || advance;

  cfv_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cfv_step u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q <= in_beat;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= result;
    end
  end

  // result beat pack
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, out_q.right_goal, out_q.left_goal, out_q.cmd_sequence,
                          out_q.cmd_enabled, out_q.command_given, out_q.command_waiting,
                          out_q.send_reply, out_q.reply_waiting, out_q.link_state};

  // checks
  `CFV_ASSERT(a_blocked_no_ready, clk_i, rst_ni, !(in_vld_q && !advance) || !s_axis_tready, "input taken while held beat is blocked")
  `CFV_ASSERT_NEXT(a_fire_loads_out, clk_i, rst_ni, fire, out_vld_q, "evaluated beat lost")
  `CFV_ASSERT(a_no_cmd_fields, clk_i, rst_ni, !(out_vld_q && !out_q.command_given) || (!out_q.cmd_enabled && out_q.cmd_sequence == 8'd0 && out_q.left_goal == 16'sd0 && out_q.right_goal == 16'sd0), "command fields set without a command")
  `CFV_ASSERT(a_sent_clears_reply, clk_i, rst_ni, !(out_vld_q && out_q.send_reply) || !out_q.reply_waiting, "reply still pending after send")
  `CFV_ASSERT(a_link_code, clk_i, rst_ni, !out_vld_q || out_q.link_state != 2'd3, "unused link state code")

endmodule

@@ hw/rtl/cfv_regs.sv @@
// apb configuration registers of the frame validator
module cfv_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfv_pkg::cfg_t     cfg_o
);

  cfv_pkg::cfg_t    cfg_q;
  cfv_pkg::reg_idx_e idx;
  logic             wr_en;

  assign idx    = cfv_pkg::reg_idx_e'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // register writes, index beyond the list is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_limit     <= cfv_pkg::TARGET_LIMIT_RST;
      cfg_q.control_frame_id <= cfv_pkg::CONTROL_ID_RST;
      cfg_q.test_request_id  <= cfv_pkg::TEST_ID_RST;
    end else if (wr_en) begin
      case (idx)
        cfv_pkg::REG_TARGET_LIMIT: cfg_q.target_limit     <= pwdata[14:0];
        cfv_pkg::REG_CONTROL_ID:   cfg_q.control_frame_id <= pwdata[10:0];
        cfv_pkg::REG_TEST_ID:      cfg_q.test_request_id  <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  // read-back
  always_comb begin
    case (idx)
      cfv_pkg::REG_TARGET_LIMIT: prdata = {17'd0, cfg_q.target_limit};
      cfv_pkg::REG_CONTROL_ID:   prdata = {21'd0, cfg_q.control_frame_id};
      cfv_pkg::REG_TEST_ID:      prdata = {21'd0, cfg_q.test_request_id};
      default:                   prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ hw/rtl/cfv_step.sv @@
// link state, held command and the per-event update logic
module cfv_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  cfv_pkg::item_t    item_i,
  input  cfv_pkg::cfg_t     cfg_i,
  output cfv_pkg::result_t  result_o
);

  logic [1:0]  link_q, link_d;
  logic        reply_q, reply_d;
  logic        pend_q, pend_d;
  logic        known_q, known_d;
  logic [7:0]  last_seq_q, last_seq_d;
  logic        hold_en_q, hold_en_d;
  logic [15:0] hold_l_q, hold_l_d;
  logic [15:0] hold_r_q, hold_r_d;

  logic        frame_ok, is_test, is_ping, is_pass, ctrl_ok, in_range;
  logic [7:0]  ver, en, seq, rsv;
  logic [15:0] lraw, rraw;
  logic signed [16:0] l_ext, r_ext, lim_pos, lim_neg;

  // payload decode
  assign ver  = item_i.payload_low[7:0];
  assign en   = item_i.payload_low[15:8];
  assign seq  = item_i.payload_low[23:16];
  assign rsv  = item_i.payload_low[31:24];
  assign lraw = item_i.payload_high[15:0];
  assign rraw = item_i.payload_high[31:16];

  // frame checks
  assign frame_ok = (item_i.length_code == cfv_pkg::FRAME_DLC) && item_i.fd_format
                    && item_i.rate_switch;
  assign is_test  = item_i.frame_id == cfg_i.test_request_id;
  assign is_ping  = (item_i.payload_low == cfv_pkg::PING_WORD)
                    && (item_i.payload_high == cfv_pkg::TEST_HIGH);
  assign is_pass  = (item_i.payload_low == cfv_pkg::PASS_WORD)
                    && (item_i.payload_high == cfv_pkg::TEST_HIGH);

  // target magnitude window
  assign l_ext    = {lraw[15], lraw};
  assign r_ext    = {rraw[15], rraw};
  assign lim_pos  = {2'b00, cfg_i.target_limit};
  assign lim_neg  = -lim_pos;
  assign in_range = (l_ext <= lim_pos) && (l_ext >= lim_neg)
                    && (r_ext <= lim_pos) && (r_ext >= lim_neg);

  // control frame acceptance
  assign ctrl_ok = (item_i.frame_id == cfg_i.control_frame_id)
                   && (link_q == cfv_pkg::LINK_PASSED)
                   && (ver == cfv_pkg::CTRL_VERSION)
                   && ((en & cfv_pkg::ENABLE_MASK) == 8'd0)
                   && (rsv == 8'd0)
                   && in_range
                   && !((en == 8'd0) && ((lraw != 16'd0) || (rraw != 16'd0)))
                   && (!known_q || (seq == last_seq_q + 8'd1));

  // next state and result
  always_comb begin
    link_d     = link_q;
    reply_d    = reply_q;
    pend_d     = pend_q;
    known_d    = known_q;
    last_seq_d = last_seq_q;
    hold_en_d  = hold_en_q;
    hold_l_d   = hold_l_q;
    hold_r_d   = hold_r_q;
    result_o   = '0;
    case (item_i.cmd)
      cfv_pkg::CMD_FRAME: begin
        if (frame_ok) begin
          if (is_test) begin
            if (is_ping) begin
              reply_d = 1'b1;
            end else if (is_pass) begin
              link_d  = cfv_pkg::LINK_PASSED;
              known_d = 1'b0;
            end else begin
              link_d = cfv_pkg::LINK_FAILED;
            end
          end else if (ctrl_ok) begin
            last_seq_d = seq;
            known_d    = 1'b1;
            hold_en_d  = en[0];
            hold_l_d   = lraw;
            hold_r_d   = rraw;
            pend_d     = 1'b1;
          end
        end
      end
      cfv_pkg::CMD_TAKE: begin
        if (pend_q) begin
          result_o.command_given = 1'b1;
          result_o.cmd_enabled   = hold_en_q;
          result_o.cmd_sequence  = last_seq_q;
          result_o.left_goal     = hold_l_q;
          result_o.right_goal    = hold_r_q;
          pend_d                 = 1'b0;
        end
      end
      cfv_pkg::CMD_SLOT: begin
        if (reply_q) begin
          if (item_i.tx_accepted) begin
            result_o.send_reply = 1'b1;
            reply_d             = 1'b0;
          end else begin
            link_d = cfv_pkg::LINK_FAILED;
          end
        end
      end
      default: begin
        reply_d = 1'b1;
      end
    endcase
    result_o.link_state      = link_d;
    result_o.reply_waiting   = reply_d;
    result_o.command_waiting = pend_d;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q     <= cfv_pkg::LINK_READY;
      reply_q    <= 1'b0;
      pend_q     <= 1'b0;
      known_q    <= 1'b0;
      last_seq_q <= 8'd0;
      hold_en_q  <= 1'b0;
      hold_l_q   <= 16'd0;
      hold_r_q   <= 16'd0;
    end else if (fire_i) begin
      link_q     <= link_d;
      reply_q    <= reply_d;
      pend_q     <= pend_d;
      known_q    <= known_d;
      last_seq_q <= last_seq_d;
      hold_en_q  <= hold_en_d;
      hold_l_q   <= hold_l_d;
      hold_r_q   <= hold_r_d;
    end
  end

endmodule

@@ bench/tb.sv @@
// self-checking testbench for the can command frame validator core
`timescale 1ns / 100ps

module tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;

  // one directed event, with the outcome written out where it is obvious
  typedef struct {
    cfv_pkg::item_t   ev;
    bit               typed;
    cfv_pkg::result_t want;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // predicted register settings and link state
  logic [14:0] lim_cfg;
  logic [10:0] ctrl_id_cfg;
  logic [10:0] test_id_cfg;
  logic [1:0]  link_mode;
  logic        reply_flag;
  logic        cmd_pending;
  logic        seq_known;
  logic [7:0]  last_seq;
  logic        held_en;
  logic [15:0] held_l;
  logic [15:0] held_r;

  cfv_pkg::result_t outcome_q[$];
  row_t    rows[$];
  bit      tx_calm = 1'b0;
  bit      rx_calm = 1'b0;
  int      mismatches = 0;
  int      events = 0;
  int      beats_out = 0;
  int      commands_out = 0;
  int      replies_out = 0;
  int      settings = 1;
  int      cycles = 0;

  can_command_frame_validator_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #6 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d outcomes outstanding", cycles, outcome_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // next link state and outcome for one accepted event
  function automatic cfv_pkg::result_t apply_event(cfv_pkg::item_t ev);
    cfv_pkg::result_t r;
    logic [7:0] ver, en, seq, rsv;
    int         l, rt, lim;
    r = '0;
    case (ev.cmd)
      cfv_pkg::CMD_FRAME: begin
        if (ev.length_code == cfv_pkg::FRAME_DLC && ev.fd_format && ev.rate_switch) begin
          if (ev.frame_id == test_id_cfg) begin
            if (ev.payload_low == cfv_pkg::PING_WORD &&
                ev.payload_high == cfv_pkg::TEST_HIGH) begin
              reply_flag = 1'b1;
            end else if (ev.payload_low == cfv_pkg::PASS_WORD &&
                         ev.payload_high == cfv_pkg::TEST_HIGH) begin
              link_mode = cfv_pkg::LINK_PASSED;
              seq_known = 1'b0;
            end else begin
              link_mode = cfv_pkg::LINK_FAILED;
            end
          end else if (ev.frame_id == ctrl_id_cfg && link_mode == cfv_pkg::LINK_PASSED) begin
            {rsv, seq, en, ver} = ev.payload_low;
            l = $signed(ev.payload_high[15:0]);
            rt = $signed(ev.payload_high[31:16]);
            lim = int'(lim_cfg);
            if (ver == cfv_pkg::CTRL_VERSION && (en & cfv_pkg::ENABLE_MASK) == 8'd0 &&
                rsv == 8'd0 &&
                l <= lim && l >= -lim && rt <= lim && rt >= -lim &&
                !(en == 8'd0 && (l != 0 || rt != 0)) &&
                (!seq_known || seq == last_seq + 8'd1)) begin
              last_seq = seq;
              seq_known = 1'b1;
              held_en = en[0];
              held_l = ev.payload_high[15:0];
              held_r = ev.payload_high[31:16];
              cmd_pending = 1'b1;
            end
          end
        end
      end
      cfv_pkg::CMD_TAKE: begin
        if (cmd_pending) begin
          r.command_given = 1'b1;
          r.cmd_enabled = held_en;
          r.cmd_sequence = last_seq;
          r.left_goal = held_l;
          r.right_goal = held_r;
          cmd_pending = 1'b0;
        end
      end
      cfv_pkg::CMD_SLOT: begin
        if (reply_flag) begin
          if (ev.tx_accepted) begin
            r.send_reply = 1'b1;
            reply_flag = 1'b0;
          end else begin
            link_mode = cfv_pkg::LINK_FAILED;
          end
        end
      end
      default: reply_flag = 1'b1;
    endcase
    r.link_state = link_mode;
    r.reply_waiting = reply_flag;
    r.command_waiting = cmd_pending;
    return r;
  endfunction

  function automatic cfv_pkg::item_t mk_frame(logic [10:0] id, logic [3:0] dlc, logic fd,
                                              logic brs, logic [31:0] lo, logic [31:0] hi);
    cfv_pkg::item_t ev;
    ev = '{cmd: cfv_pkg::CMD_FRAME, frame_id: id, length_code: dlc, fd_format: fd,
           rate_switch: brs, payload_low: lo, payload_high: hi, tx_accepted: 1'b1};
    return ev;
  endfunction

  // well formed control frame on the reset control id
  function automatic cfv_pkg::item_t mk_ctrl(logic [7:0] ver, logic [7:0] en, logic [7:0] seq,
                                             logic [7:0] rsv, logic [15:0] l, logic [15:0] r);
    return mk_frame(cfv_pkg::CONTROL_ID_RST, cfv_pkg::FRAME_DLC, 1'b1, 1'b1,
                    {rsv, seq, en, ver}, {r, l});
  endfunction

  // non-frame event with every unused field at all ones
  function automatic cfv_pkg::item_t mk_event(cfv_pkg::cmd_e c, logic tx);
    cfv_pkg::item_t ev;
    ev = '{cmd: c, frame_id: '1, length_code: '1, fd_format: 1'b1, rate_switch: 1'b1,
           payload_low: '1, payload_high: '1, tx_accepted: tx};
    return ev;
  endfunction

  function automatic cfv_pkg::result_t quiet(logic [1:0] link, logic reply, logic sent,
                                             logic waiting);
    cfv_pkg::result_t r;
    r = '0;
    r.link_state = link;
    r.reply_waiting = reply;
    r.send_reply = sent;
    r.command_waiting = waiting;
    return r;
  endfunction

  task automatic add_row(input cfv_pkg::item_t ev, input bit typed,
                         input cfv_pkg::result_t want);
    rows.push_back('{ev, typed, want});
  endtask

  // offer one event beat, then record its outcome once accepted
  task automatic send_beat(input cfv_pkg::item_t ev, input bit typed,
                           input cfv_pkg::result_t want);
    int               gap;
    cfv_pkg::result_t r;
    gap = tx_calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'b0, ev.tx_accepted, ev.payload_high, ev.payload_low, ev.rate_switch,
                     ev.fd_format, ev.length_code, ev.frame_id};
    s_axis_tuser <= ev.cmd;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    r = apply_event(ev);
    outcome_q.push_back(typed ? want : r);
    events++;
  endtask

  // let the block run dry before registers change
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic wr_reg(input cfv_pkg::reg_idx_e idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      cfv_pkg::REG_TARGET_LIMIT: lim_cfg = value[14:0];
      cfv_pkg::REG_CONTROL_ID:   ctrl_id_cfg = value[10:0];
      default:                   test_id_cfg = value[10:0];
    endcase
  endtask

  // random events, mostly well formed frames around the current link state
  task automatic run_phase(input int n);
    cfv_pkg::item_t ev;
    logic [95:0] raw;
    logic [7:0]  ver, en, seq, rsv;
    logic [15:0] lt, rt;
    int          pick;
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) begin
        tx_calm = ($urandom_range(0, 3) == 0);
        rx_calm = ($urandom_range(0, 3) == 0);
      end
      raw = {$urandom, $urandom, $urandom};
      ev = raw[83:0];
      if ($urandom_range(0, 99) >= 10) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          ev.cmd = cfv_pkg::CMD_FRAME;
          if ($urandom_range(0, 9) != 0) begin
            ev.length_code = cfv_pkg::FRAME_DLC;
            ev.fd_format = 1'b1;
            ev.rate_switch = 1'b1;
          end
          pick = $urandom_range(0, 99);
          if (pick < 25) begin
            // link test request
            ev.frame_id = test_id_cfg;
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
              ev.payload_low = cfv_pkg::PING_WORD;
              ev.payload_high = cfv_pkg::TEST_HIGH;
            end else if (pick < 8) begin
              ev.payload_low = cfv_pkg::PASS_WORD;
              ev.payload_high = cfv_pkg::TEST_HIGH;
            end else if (pick < 9) begin
              ev.payload_high = cfv_pkg::TEST_HIGH;
            end
          end else if (pick < 75) begin
            // control frame, mostly passing the payload checks
            ev.frame_id = ctrl_id_cfg;
            ver = ($urandom_range(0, 9) != 0) ? cfv_pkg::CTRL_VERSION : 8'($urandom);
            en = ($urandom_range(0, 9) != 0) ? 8'($urandom_range(0, 1)) : 8'($urandom);
            seq = (seq_known && $urandom_range(0, 4) != 0) ? last_seq + 8'd1 : 8'($urandom);
            rsv = ($urandom_range(0, 9) != 0) ? 8'd0 : 8'($urandom);
            case ($urandom_range(0, 9))
              0: begin
                lt = 16'($urandom);
                rt = 16'($urandom);
              end
              1: begin
                lt = 16'(lim_cfg + $urandom_range(0, 1));
                rt = 16'(lim_cfg + $urandom_range(0, 1));
              end
              default: begin
                lt = 16'($urandom_range(0, lim_cfg));
                rt = 16'($urandom_range(0, lim_cfg));
              end
            endcase
            if ($urandom_range(0, 1) != 0) lt = -lt;
            if ($urandom_range(0, 1) != 0) rt = -rt;
            if (en == 8'd0 && $urandom_range(0, 4) != 0) begin
              lt = '0;
              rt = '0;
            end
            ev.payload_low = {rsv, seq, en, ver};
            ev.payload_high = {rt, lt};
          end
        end else if (pick < 75) begin
          ev.cmd = cfv_pkg::CMD_TAKE;
        end else if (pick < 90) begin
          ev.cmd = cfv_pkg::CMD_SLOT;
          ev.tx_accepted = ($urandom_range(0, 4) != 0);
        end else begin
          ev.cmd = cfv_pkg::CMD_RESPOND;
        end
      end
      send_beat(ev, 1'b0, '0);
    end
  endtask

  // result side: random stalls, two long hold-offs, field by field compare
  initial begin : sink
    int               stall;
    cfv_pkg::result_t got, want;
    logic [47:0]      d;
    bit               bad;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = rx_calm ? 0 : $urandom_range(0, 4);
      if (beats_out == 400 || beats_out == 900) stall = HOLD_CYCLES;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid !== 1'b1);
      d = m_axis_tdata;
      got.link_state = d[1:0];
      got.reply_waiting = d[2];
      got.send_reply = d[3];
      got.command_waiting = d[4];
      got.command_given = d[5];
      got.cmd_enabled = d[6];
      got.cmd_sequence = d[14:7];
      got.left_goal = d[30:15];
      got.right_goal = d[46:31];
      if (got.command_given === 1'b1) commands_out++;
      if (got.send_reply === 1'b1) replies_out++;
      if (outcome_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result beat %0d with no outcome pending: %h", beats_out, d);
      end else begin
        want = outcome_q.pop_front();
        bad = (got.link_state !== want.link_state) ||
              (got.reply_waiting !== want.reply_waiting) ||
              (got.send_reply !== want.send_reply) ||
              (got.command_waiting !== want.command_waiting) ||
              (got.command_given !== want.command_given) ||
              (got.cmd_enabled !== want.cmd_enabled) ||
              (got.cmd_sequence !== want.cmd_sequence) ||
              (got.left_goal !== want.left_goal) ||
              (got.right_goal !== want.right_goal);
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("beat %0d exp: link %0d reply %b sent %b wait %b given %b en %b seq %0d l %0d r %0d",
                     beats_out, want.link_state, want.reply_waiting, want.send_reply,
                     want.command_waiting, want.command_given, want.cmd_enabled,
                     want.cmd_sequence, want.left_goal, want.right_goal);
            $display("beat %0d got: link %0d reply %b sent %b wait %b given %b en %b seq %0d l %0d r %0d",
                     beats_out, got.link_state, got.reply_waiting, got.send_reply,
                     got.command_waiting, got.command_given, got.cmd_enabled,
                     got.cmd_sequence, got.left_goal, got.right_goal);
          end
        end
      end
      beats_out++;
    end
  end

  // stimulus
  initial begin : source
    cfv_pkg::result_t given;
    lim_cfg = cfv_pkg::TARGET_LIMIT_RST;
    ctrl_id_cfg = cfv_pkg::CONTROL_ID_RST;
    test_id_cfg = cfv_pkg::TEST_ID_RST;
    link_mode = cfv_pkg::LINK_READY;
    reply_flag = 1'b0;
    cmd_pending = 1'b0;
    seq_known = 1'b0;
    last_seq = '0;
    held_en = 1'b0;
    held_l = '0;
    held_r = '0;

    // directed table, reset register values
    given = quiet(cfv_pkg::LINK_PASSED, 1'b0, 1'b0, 1'b0);
    given.command_given = 1'b1;
    given.cmd_enabled = 1'b1;
    given.cmd_sequence = 8'd255;
    given.left_goal = 16'sd1000;
    given.right_goal = -16'sd1000;
    add_row(mk_event(cfv_pkg::CMD_TAKE, 1'b1), 1'b1,
            quiet(cfv_pkg::LINK_READY, 1'b0, 1'b0, 1'b0));
    add_row(mk_event(cfv_pkg::CMD_SLOT, 1'b1), 1'b1,
            quiet(cfv_pkg::LINK_READY, 1'b0, 1'b0, 1'b0));
    add_row(mk_frame(cfv_pkg::TEST_ID_RST, 4'd7, 1'b1, 1'b1, cfv_pkg::PASS_WORD,
                     cfv_pkg::TEST_HIGH), 1'b1,
            quiet(cfv_pkg::LINK_READY, 1'b0, 1'b0, 1'b0));
    add_row(mk_frame(cfv_pkg::TEST_ID_RST, cfv_pkg::FRAME_DLC, 1'b0, 1'b1, cfv_pkg::PASS_WORD,
                     cfv_pkg::TEST_HIGH), 1'b1,
            quiet(cfv_pkg::LINK_READY, 1'b0, 1'b0, 1'b0));
    add_row(mk_frame(cfv_pkg::TEST_ID_RST, cfv_pkg::FRAME_DLC, 1'b1, 1'b0, cfv_pkg::PASS_WORD,
                     cfv_pkg::TEST_HIGH), 1'b1,
            quiet(cfv_pkg::LINK_READY, 1'b0, 1'b0, 1'b0));
    add_row(mk_frame(cfv_pkg::TEST_ID_RST, 4'd15, 1'b1, 1'b1, cfv_pkg::PASS_WORD,
                     cfv_pkg::TEST_HIGH), 1'b1,
            quiet(cfv_pkg::LINK_READY, 1'b0, 1'b0, 1'b0));
    // control frame before the link has passed
    add_row(mk_ctrl(cfv_pkg::CTRL_VERSION, 8'd1, 8'd0, 8'd0, 16'd5, 16'd5), 1'b1,
            quiet(cfv_pkg::LINK_READY, 1'b0, 1'b0, 1'b0));
    add_row(mk_frame(cfv_pkg::TEST_ID_RST, cfv_pkg::FRAME_DLC, 1'b1, 1'b1, cfv_pkg::PING_WORD,
                     cfv_pkg::TEST_HIGH), 1'b1,
            quiet(cfv_pkg::LINK_READY, 1'b1, 1'b0, 1'b0));
    // refused transmit keeps the reply and fails the link
    add_row(mk_event(cfv_pkg::CMD_SLOT, 1'b0), 1'b1,
            quiet(cfv_pkg::LINK_FAILED, 1'b1, 1'b0, 1'b0));
    add_row(mk_event(cfv_pkg::CMD_SLOT, 1'b1), 1'b1,
            quiet(cfv_pkg::LINK_FAILED, 1'b0, 1'b1, 1'b0));
    add_row(mk_frame(cfv_pkg::TEST_ID_RST, cfv_pkg::FRAME_DLC, 1'b1, 1'b1, cfv_pkg::PASS_WORD,
                     cfv_pkg::TEST_HIGH), 1'b1,
            quiet(cfv_pkg::LINK_PASSED, 1'b0, 1'b0, 1'b0));
    // first control frame after pass takes any sequence, targets at the limit
    add_row(mk_ctrl(cfv_pkg::CTRL_VERSION, 8'd1, 8'd255, 8'd0, 16'd1000, -16'sd1000), 1'b1,
            quiet(cfv_pkg::LINK_PASSED, 1'b0, 1'b0, 1'b1));
    add_row(mk_event(cfv_pkg::CMD_TAKE, 1'b0), 1'b1, given);
    // sequence wraps from 255 to 0
    add_row(mk_ctrl(cfv_pkg::CTRL_VERSION, 8'd1, 8'd0, 8'd0, -16'sd1000, 16'd1000), 1'b0, '0);
    add_row(mk_ctrl(cfv_pkg::CTRL_VERSION, 8'd1, 8'd2, 8'd0, 16'd0, 16'd0), 1'b0, '0);
    add_row(mk_ctrl(cfv_pkg::CTRL_VERSION, 8'd0, 8'd1, 8'd0, 16'd5, 16'd0), 1'b0, '0);
    add_row(mk_ctrl(8'd2, 8'd1, 8'd1, 8'd0, 16'd0, 16'd0), 1'b0, '0);
    add_row(mk_ctrl(cfv_pkg::CTRL_VERSION, 8'd2, 8'd1, 8'd0, 16'd0, 16'd0), 1'b0, '0);
    add_row(mk_ctrl(cfv_pkg::CTRL_VERSION, 8'd1, 8'd1, 8'h80, 16'd0, 16'd0), 1'b0, '0);
    add_row(mk_ctrl(cfv_pkg::CTRL_VERSION, 8'd1, 8'd1, 8'd0, 16'd1001, 16'd0), 1'b0, '0);
    add_row(mk_ctrl(cfv_pkg::CTRL_VERSION, 8'd1, 8'd1, 8'd0, 16'd0, -16'sd1001), 1'b0, '0);
    add_row(mk_ctrl(cfv_pkg::CTRL_VERSION, 8'd0, 8'd1, 8'd0, 16'd0, 16'd0), 1'b0, '0);
    // well formed frame on an unknown id
    add_row(mk_frame(11'h7FF, cfv_pkg::FRAME_DLC, 1'b1, 1'b1, cfv_pkg::PING_WORD,
                     cfv_pkg::TEST_HIGH), 1'b0, '0);
    add_row(mk_event(cfv_pkg::CMD_RESPOND, 1'b0), 1'b0, '0);
    add_row(mk_event(cfv_pkg::CMD_TAKE, 1'b0), 1'b0, '0);
    add_row(mk_frame(cfv_pkg::TEST_ID_RST, cfv_pkg::FRAME_DLC, 1'b1, 1'b1, cfv_pkg::PING_WORD,
                     32'd0), 1'b0, '0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_beat(rows[i].ev, rows[i].typed, rows[i].want);
    settle();

    // random phases over several register settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: begin
          wr_reg(cfv_pkg::REG_TARGET_LIMIT, 32'd0);
          wr_reg(cfv_pkg::REG_CONTROL_ID, 32'd0);
          wr_reg(cfv_pkg::REG_TEST_ID, 32'd2047);
        end
        2: begin
          wr_reg(cfv_pkg::REG_TARGET_LIMIT, 32'd32767);
          wr_reg(cfv_pkg::REG_CONTROL_ID, 32'd2047);
          wr_reg(cfv_pkg::REG_TEST_ID, 32'd0);
        end
        3: begin
          // control and test ids equal: test request wins
          wr_reg(cfv_pkg::REG_TARGET_LIMIT, 32'd1000);
          wr_reg(cfv_pkg::REG_CONTROL_ID, 32'h155);
          wr_reg(cfv_pkg::REG_TEST_ID, 32'h155);
        end
        4: begin
          wr_reg(cfv_pkg::REG_TARGET_LIMIT, $urandom_range(1, 32766));
          wr_reg(cfv_pkg::REG_CONTROL_ID, $urandom_range(0, 2047));
          wr_reg(cfv_pkg::REG_TEST_ID, $urandom_range(0, 2047));
        end
        5: begin
          wr_reg(cfv_pkg::REG_TARGET_LIMIT, 32'(cfv_pkg::TARGET_LIMIT_RST));
          wr_reg(cfv_pkg::REG_CONTROL_ID, 32'(cfv_pkg::CONTROL_ID_RST));
          wr_reg(cfv_pkg::REG_TEST_ID, 32'(cfv_pkg::TEST_ID_RST));
        end
        default: ;
      endcase
      if (ph > 0) settings++;
      run_phase(205);
      settle();
    end

    $display("%0d events over %0d register settings, %0d result beats checked",
             events, settings, beats_out);
    $display("%0d commands handed out, %0d replies sent, %0d mismatches",
             commands_out, replies_out, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
